// ----- src/mqtt_response_frame_parser_macros.svh -----
// Assertion macros shared by the checker of the MQTT response frame parser.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MQTT_RESPONSE_FRAME_PARSER_MACROS_SVH
`define MQTT_RESPONSE_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MRFP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrfp assertion failed");

// next-cycle implication, checked outside reset
`define MRFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrfp assertion failed");

`endif

// ----- src/mrfp_pkg.sv -----
// Package for the MQTT response frame parser: result type, phase type and codes.
// No dependencies; used by the top level and its checker.
package mrfp_pkg;

    // longest remaining-length field in bytes
    localparam int MAX_LEN_BYTES = 4;
    // result queue entries
    localparam int QUEUE_DEPTH   = 3;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // frame status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PUBLISH    = 3'd1;
    localparam logic [2:0] ST_PING_ACK   = 3'd2;
    localparam logic [2:0] ST_SUB_ACK    = 3'd3;
    localparam logic [2:0] ST_UNEXPECTED = 3'd4;
    localparam logic [2:0] ST_REFUSED    = 3'd5;

    // frame types (upper nibble of the type byte)
    localparam logic [3:0] FT_CONNACK  = 4'd2;
    localparam logic [3:0] FT_PUBLISH  = 4'd3;
    localparam logic [3:0] FT_SUBACK   = 4'd9;
    localparam logic [3:0] FT_UNSUBACK = 4'd11;
    localparam logic [3:0] FT_PINGRESP = 4'd13;

    // configuration register indexes
    localparam logic [1:0] CFG_PUBLISH_EN   = 2'd0;
    localparam logic [1:0] CFG_PING_EN      = 2'd1;
    localparam logic [1:0] CFG_SUBSCRIBE_EN = 2'd2;
    localparam logic [1:0] CFG_UNSUB_EN     = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [3:0]  frame_type;
        logic [15:0] packet_ident;
        logic        sub_granted;
        logic [27:0] payload_length;
        logic        frame_end;
    } t_result;

endpackage

// ----- src/mqtt_response_frame_parser.sv -----
// MQTT response frame parser: one received byte per cycle while the input is not stalled; the
// frame phase, length and body head update on acceptance and each result enters a three-entry
// output queue. Results are registered into the queue and shown from its head. Throughput: one
// byte per cycle; a byte may give two results (a publish byte then the status), each taking its
// own output slot, and input stalls while two or more results wait in the queue.
// Reset (synchronous, active low) empties the queue, disables all handlers, waits for a type byte.
module mqtt_response_frame_parser
    import mrfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_status,
    output logic [3:0]  o_frame_type,
    output logic [15:0] o_packet_ident,
    output logic        o_sub_granted,
    output logic [27:0] o_payload_length,
    output logic        o_frame_end
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // enables
    logic r_pub_en, r_ping_en, r_sub_en, r_unsub_en;

    // frame state
    t_phase      r_phase,     n_phase;
    logic [3:0]  r_type,      n_type;
    logic [27:0] r_len,       n_len;
    logic [1:0]  r_len_idx,   n_len_idx;
    logic [27:0] r_body_cnt,  n_body_cnt;
    logic [7:0]  r_topic_len, n_topic_len;
    logic [7:0]  r_head [0:2];
    logic [7:0]  n_head [0:2];

    // result queue
    t_result          r_queue [0:QUEUE_DEPTH-1];
    t_result          n_queue [0:QUEUE_DEPTH-1];
    logic [CNT_W-1:0] r_count, n_count;

    logic    in_acc, out_acc;
    logic    has_byte, has_stat;
    t_result res_byte, res_stat;

    // build the status result that closes a frame
    function automatic t_result make_status(
        input logic [3:0]  ft,
        input logic [27:0] len,
        input logic [7:0]  topic,
        input logic [7:0]  h0,
        input logic [7:0]  h1,
        input logic [7:0]  h2,
        input logic        pub_en,
        input logic        ping_en,
        input logic        sub_en,
        input logic        unsub_en
    );
        t_result    r;
        logic [8:0] topic_plus2;
        r              = '0;
        r.kind         = KIND_STATUS;
        r.frame_type   = ft;
        r.frame_end    = 1'b1;
        r.status       = ST_OK;
        topic_plus2    = {1'b0, topic} + 9'd2;
        if (ft == FT_PUBLISH && pub_en) begin
            if (len < 28'd6 || 28'(topic_plus2) > len) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status         = ST_PUBLISH;
                r.payload_length = len - 28'(topic_plus2);
            end
        end else if (ft == FT_PINGRESP && ping_en) begin
            r.status = ST_PING_ACK;
        end else if (ft == FT_SUBACK && sub_en) begin
            if (len != 28'd3 || (h2 != 8'h00 && h2 != 8'h80)) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status       = ST_SUB_ACK;
                r.packet_ident = {h0, h1};
                r.sub_granted  = (h2 == 8'h00);
            end
        end else if (ft == FT_UNSUBACK && unsub_en) begin
            if (len != 28'd2) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status       = ST_SUB_ACK;
                r.packet_ident = {h0, h1};
            end
        end else if (ft == FT_CONNACK) begin
            if (len != 28'd2) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = (h0 != 8'h00) ? ST_REFUSED : ST_OK;
            end
        end
        return r;
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_count >= CNT_W'(QUEUE_DEPTH - 1));

    // frame parsing: next state and results of the accepted byte
    always_comb begin
        logic [27:0] shifted;
        logic [27:0] sum;
        logic [27:0] c;
        logic [8:0]  topic_plus2;
        logic        pub_active;
        n_phase     = r_phase;
        n_type      = r_type;
        n_len       = r_len;
        n_len_idx   = r_len_idx;
        n_body_cnt  = r_body_cnt;
        n_topic_len = r_topic_len;
        for (int i = 0; i < 3; i++) begin
            n_head[i] = r_head[i];
        end
        has_byte    = 1'b0;
        has_stat    = 1'b0;
        res_byte    = '0;
        res_stat    = '0;
        shifted     = '0;
        sum         = '0;
        c           = r_body_cnt;
        topic_plus2 = {1'b0, r_topic_len} + 9'd2;
        pub_active  = (r_type == FT_PUBLISH) && r_pub_en && (r_len >= 28'd6);

        if (in_acc) begin
            unique case (r_phase)
                PH_LEN: begin
                    // accumulate seven length bits per byte
                    case (r_len_idx)
                        2'd0:    shifted = {21'd0, i_rx_byte[6:0]};
                        2'd1:    shifted = {14'd0, i_rx_byte[6:0], 7'd0};
                        2'd2:    shifted = {7'd0, i_rx_byte[6:0], 14'd0};
                        default: shifted = {i_rx_byte[6:0], 21'd0};
                    endcase
                    sum   = r_len + shifted;
                    n_len = sum;
                    if (i_rx_byte[7]) begin
                        if (({1'b0, r_len_idx} + 3'd1) >= 3'(MAX_LEN_BYTES)) begin
                            // overlong length: close the frame at once
                            n_len               = '0;
                            has_stat            = 1'b1;
                            res_stat.kind       = KIND_STATUS;
                            res_stat.status     = ST_UNEXPECTED;
                            res_stat.frame_type = r_type;
                            res_stat.frame_end  = 1'b1;
                            n_phase             = PH_TYPE;
                        end else begin
                            n_len_idx = r_len_idx + 2'd1;
                        end
                    end else begin
                        n_body_cnt  = '0;
                        n_topic_len = '0;
                        for (int i = 0; i < 3; i++) begin
                            n_head[i] = '0;
                        end
                        if (sum == 28'd0) begin
                            // empty body: status now
                            has_stat = 1'b1;
                            res_stat = make_status(r_type, sum, 8'd0, 8'd0, 8'd0, 8'd0,
                                                   r_pub_en, r_ping_en, r_sub_en, r_unsub_en);
                            n_phase  = PH_TYPE;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    // capture the first three body bytes
                    for (int i = 0; i < 3; i++) begin
                        if (c == 28'(i)) begin
                            n_head[i] = i_rx_byte;
                        end
                    end
                    if (pub_active) begin
                        if (c == 28'd1) begin
                            n_topic_len = i_rx_byte;
                        end
                        if (c >= 28'd2) begin
                            has_byte            = 1'b1;
                            res_byte.kind       = (c < 28'(topic_plus2)) ? KIND_TOPIC
                                                                         : KIND_PAYLOAD;
                            res_byte.data_byte  = i_rx_byte;
                            res_byte.frame_type = r_type;
                        end
                    end
                    n_body_cnt = c + 28'd1;
                    if (n_body_cnt >= r_len) begin
                        has_stat = 1'b1;
                        res_stat = make_status(r_type, r_len, n_topic_len,
                                               n_head[0], n_head[1], n_head[2],
                                               r_pub_en, r_ping_en, r_sub_en, r_unsub_en);
                        n_phase  = PH_TYPE;
                    end
                end
                default: begin
                    // type byte: start a new frame
                    n_type     = i_rx_byte[7:4];
                    n_len      = '0;
                    n_len_idx  = '0;
                    n_body_cnt = '0;
                    n_phase    = PH_LEN;
                end
            endcase
        end
    end

    // result queue: drop the head on pop, append new results behind the rest
    always_comb begin
        t_result          s [0:QUEUE_DEPTH-1];
        t_result          r0;
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] second;
        logic             push0;
        logic             push1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            s[i] = out_acc ? r_queue[i+1] : r_queue[i];
        end
        s[QUEUE_DEPTH-1] = r_queue[QUEUE_DEPTH-1];
        base    = r_count - CNT_W'(out_acc);
        push0   = has_byte || has_stat;
        push1   = has_byte && has_stat;
        r0      = has_byte ? res_byte : res_stat;
        second  = base + CNT_W'(1);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_queue[i] = s[i];
            if (push0 && base == CNT_W'(i)) begin
                n_queue[i] = r0;
            end
            if (push1 && second == CNT_W'(i)) begin
                n_queue[i] = res_stat;
            end
        end
        n_count = base + CNT_W'(push0) + CNT_W'(push1);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_en   <= 1'b0;
            r_ping_en  <= 1'b0;
            r_sub_en   <= 1'b0;
            r_unsub_en <= 1'b0;
            r_phase    <= PH_TYPE;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PUBLISH_EN:   r_pub_en   <= i_cfg_data;
                    CFG_PING_EN:      r_ping_en  <= i_cfg_data;
                    CFG_SUBSCRIBE_EN: r_sub_en   <= i_cfg_data;
                    CFG_UNSUB_EN:     r_unsub_en <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // frame state: cleared to zero on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type      <= '0;
            r_len       <= '0;
            r_len_idx   <= '0;
            r_body_cnt  <= '0;
            r_topic_len <= '0;
            for (int i = 0; i < 3; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_type      <= n_type;
            r_len       <= n_len;
            r_len_idx   <= n_len_idx;
            r_body_cnt  <= n_body_cnt;
            r_topic_len <= n_topic_len;
            for (int i = 0; i < 3; i++) begin
                r_head[i] <= n_head[i];
            end
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_queue[i] <= n_queue[i];
        end
    end

    // show the queue head
    assign o_out_valid      = (r_count != '0);
    assign o_kind           = r_queue[0].kind;
    assign o_data_byte      = r_queue[0].data_byte;
    assign o_status         = r_queue[0].status;
    assign o_frame_type     = r_queue[0].frame_type;
    assign o_packet_ident   = r_queue[0].packet_ident;
    assign o_sub_granted    = r_queue[0].sub_granted;
    assign o_payload_length = r_queue[0].payload_length;
    assign o_frame_end      = r_queue[0].frame_end;

endmodule

// ----- src/mrfp_checker.sv -----
// Port-level checker for the MQTT response frame parser, bound to the top level.
// Depends on mrfp_pkg and mqtt_response_frame_parser_macros.svh.
`include "mqtt_response_frame_parser_macros.svh"

module mrfp_checker
    import mrfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_data_byte,
    input logic [2:0]  i_status,
    input logic [3:0]  i_frame_type,
    input logic [15:0] i_packet_ident,
    input logic [27:0] i_payload_length,
    input logic        i_frame_end
);

    // the status item, and only it, ends a frame
    `MRFP_ASSERT_IMP(a_end_is_status, i_out_valid, i_frame_end == (i_kind == KIND_STATUS))

    // byte items carry no frame summary
    `MRFP_ASSERT_IMP(a_byte_item_clean, i_out_valid && i_kind != KIND_STATUS, i_status == ST_OK && i_packet_ident == 16'd0 && i_payload_length == 28'd0)

    // only a connect acknowledge can be refused
    `MRFP_ASSERT_IMP(a_refused_connack, i_out_valid && i_status == ST_REFUSED, i_frame_type == FT_CONNACK)

    // a stalled item holds
    `MRFP_ASSERT_NEXT(a_stall_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_kind) && $stable(i_data_byte) && $stable(i_status))

endmodule

bind mqtt_response_frame_parser mrfp_checker u_mrfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_kind           (o_kind),
    .i_data_byte      (o_data_byte),
    .i_status         (o_status),
    .i_frame_type     (o_frame_type),
    .i_packet_ident   (o_packet_ident),
    .i_payload_length (o_payload_length),
    .i_frame_end      (o_frame_end)
);

// ----- dv/mqtt_response_frame_parser_test.sv -----
// Self-checking bench for mqtt_response_frame_parser: directed frames, then random frames
// under several handler settings, each result checked against an in-bench frame predictor.
// Depends on mrfp_pkg and the mqtt_response_frame_parser RTL.
`timescale 1ns / 1ps

module mqtt_response_frame_parser_test;
    import mrfp_pkg::*;

    // directed stimulus row: a byte, and where obvious, the status it must close with
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [2:0] st;
        logic [3:0] ft;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_PUBLISH_EN;
    logic        i_cfg_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_status;
    logic [3:0]  o_frame_type;
    logic [15:0] o_packet_ident;
    logic        o_sub_granted;
    logic [27:0] o_payload_length;
    logic        o_frame_end;

    // predictor copy of the parser state and the handler enables
    t_phase      rx_phase = PH_TYPE;
    logic [3:0]  cur_type = '0;
    logic [27:0] len_sum = '0;
    logic [1:0]  len_idx = '0;
    logic [27:0] body_seen = '0;
    logic [7:0]  topic_len = '0;
    logic [7:0]  head [3] = '{8'h00, 8'h00, 8'h00};
    logic        en_publish = 1'b0;
    logic        en_ping = 1'b0;
    logic        en_sub = 1'b0;
    logic        en_unsub = 1'b0;

    t_result     pending_results [$];
    logic [7:0]  byte_queue [$];
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          results_checked = 0;
    int          result_errors = 0;
    bit          hold_request = 1'b0;

    t_row directed_rows [24] = '{
        '{8'hFF, 1'b0, ST_OK, FT_CONNACK},
        '{8'hFF, 1'b0, ST_OK, FT_CONNACK},
        '{8'hFF, 1'b0, ST_OK, FT_CONNACK},
        '{8'hFF, 1'b0, ST_OK, FT_CONNACK},
        '{8'hFF, 1'b1, ST_UNEXPECTED, 4'hF},     // fourth length byte asks for a fifth
        '{8'hD0, 1'b0, ST_OK, FT_CONNACK},
        '{8'h00, 1'b1, ST_PING_ACK, FT_PINGRESP}, // empty body closes on the length byte
        '{8'h2F, 1'b0, ST_OK, FT_CONNACK},       // type flags set, ignored
        '{8'h02, 1'b0, ST_OK, FT_CONNACK},
        '{8'h01, 1'b0, ST_OK, FT_CONNACK},
        '{8'h00, 1'b1, ST_REFUSED, FT_CONNACK},
        '{8'h90, 1'b0, ST_OK, FT_CONNACK},
        '{8'h03, 1'b0, ST_OK, FT_CONNACK},
        '{8'h12, 1'b0, ST_OK, FT_CONNACK},
        '{8'h34, 1'b0, ST_OK, FT_CONNACK},
        '{8'h80, 1'b0, ST_OK, FT_CONNACK},       // subscription denied
        '{8'h30, 1'b0, ST_OK, FT_CONNACK},
        '{8'h06, 1'b0, ST_OK, FT_CONNACK},
        '{8'h00, 1'b0, ST_OK, FT_CONNACK},
        '{8'h01, 1'b0, ST_OK, FT_CONNACK},
        '{8'h41, 1'b0, ST_OK, FT_CONNACK},
        '{8'hFF, 1'b0, ST_OK, FT_CONNACK},
        '{8'h00, 1'b0, ST_OK, FT_CONNACK},
        '{8'h80, 1'b0, ST_OK, FT_CONNACK}
    };

    mqtt_response_frame_parser uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_status         (o_status),
        .o_frame_type     (o_frame_type),
        .o_packet_ident   (o_packet_ident),
        .o_sub_granted    (o_sub_granted),
        .o_payload_length (o_payload_length),
        .o_frame_end      (o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    // status that closes the current frame
    function automatic t_result frame_status();
        t_result r;
        r = '0;
        r.kind = KIND_STATUS;
        r.frame_type = cur_type;
        r.frame_end = 1'b1;
        if (cur_type == FT_PUBLISH && en_publish) begin
            if (len_sum < 6 || int'(topic_len) + 2 > int'(len_sum)) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = ST_PUBLISH;
                r.payload_length = len_sum - topic_len - 28'd2;
            end
        end else if (cur_type == FT_PINGRESP && en_ping) begin
            r.status = ST_PING_ACK;
        end else if (cur_type == FT_SUBACK && en_sub) begin
            if (len_sum != 3 || (head[2] != 8'h00 && head[2] != 8'h80)) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = ST_SUB_ACK;
                r.packet_ident = {head[0], head[1]};
                r.sub_granted = (head[2] == 8'h00);
            end
        end else if (cur_type == FT_UNSUBACK && en_unsub) begin
            if (len_sum != 2) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r.status = ST_SUB_ACK;
                r.packet_ident = {head[0], head[1]};
            end
        end else if (cur_type == FT_CONNACK) begin
            if (len_sum != 2)
                r.status = ST_UNEXPECTED;
            else
                r.status = (head[0] != 8'h00) ? ST_REFUSED : ST_OK;
        end
        return r;
    endfunction

    // advance the predictor by one received byte and queue the results it causes
    task automatic predict_byte(input logic [7:0] b);
        t_result     r;
        logic [27:0] c;
        case (rx_phase)
            PH_LEN: begin
                len_sum = len_sum + ({21'd0, b[6:0]} << (7 * len_idx));
                if (b[7]) begin
                    if (len_idx + 1 >= MAX_LEN_BYTES) begin
                        len_sum = '0;
                        r = '0;
                        r.kind = KIND_STATUS;
                        r.status = ST_UNEXPECTED;
                        r.frame_type = cur_type;
                        r.frame_end = 1'b1;
                        pending_results.push_back(r);
                        rx_phase = PH_TYPE;
                    end else begin
                        len_idx = len_idx + 2'd1;
                    end
                end else begin
                    body_seen = '0;
                    topic_len = '0;
                    head = '{8'h00, 8'h00, 8'h00};
                    if (len_sum == 0) begin
                        pending_results.push_back(frame_status());
                        rx_phase = PH_TYPE;
                    end else begin
                        rx_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                c = body_seen;
                if (c < 3)
                    head[c] = b;
                // publish bodies stream topic, then payload
                if (cur_type == FT_PUBLISH && en_publish && len_sum >= 6) begin
                    if (c == 1)
                        topic_len = b;
                    if (c >= 2) begin
                        r = '0;
                        r.kind = (c < topic_len + 2) ? KIND_TOPIC : KIND_PAYLOAD;
                        r.data_byte = b;
                        r.frame_type = cur_type;
                        pending_results.push_back(r);
                    end
                end
                body_seen = c + 28'd1;
                if (body_seen >= len_sum) begin
                    pending_results.push_back(frame_status());
                    rx_phase = PH_TYPE;
                end
            end
            default: begin
                cur_type = b[7:4];
                len_sum = '0;
                len_idx = '0;
                body_seen = '0;
                rx_phase = PH_LEN;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        predict_byte(b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    // random byte; a length opened by noise stays below 512
    task automatic send_noise();
        logic [7:0] b;
        b = 8'($urandom());
        if (rx_phase == PH_LEN && len_idx == 2'd1)
            b[6:2] = '0;
        else if (rx_phase == PH_LEN && len_idx > 2'd1)
            b[6:0] = '0;
        send_byte(b);
    endtask

    // one frame, mostly well formed with random content
    task automatic send_frame();
        logic [3:0] ftype;
        logic [7:0] body_byte;
        int         len, groups, total, topic_max;
        // broken sequence: random bytes, then run out whatever frame they opened
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) send_noise();
            while (rx_phase != PH_TYPE)
                send_noise();
            return;
        end
        case ($urandom_range(0, 9))
            0, 1:    ftype = FT_CONNACK;
            2, 3, 4: ftype = FT_PUBLISH;
            5:       ftype = FT_SUBACK;
            6:       ftype = FT_UNSUBACK;
            7:       ftype = FT_PINGRESP;
            default: ftype = 4'($urandom());
        endcase
        send_byte({ftype, 4'($urandom())});
        // overlong remaining length: four bytes that each ask for another
        if ($urandom_range(0, 24) == 0) begin
            repeat (4) send_byte(8'($urandom()) | 8'h80);
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(0, 8);
        end else begin
            case (ftype)
                FT_CONNACK, FT_UNSUBACK: len = 2;
                FT_SUBACK:               len = 3;
                FT_PINGRESP:             len = 0;
                FT_PUBLISH: len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                              : $urandom_range(6, 24);
                default:                 len = $urandom_range(0, 12);
            endcase
        end
        // length field, sometimes padded with empty continuation groups
        groups = (len > 127) ? 2 : 1;
        total = ($urandom_range(0, 4) == 0) ? $urandom_range(groups, MAX_LEN_BYTES) : groups;
        for (int i = 0; i < total; i++)
            send_byte({i < total - 1, 7'((len >> (7 * i)) & 'h7F)});
        topic_max = (len - 2 < 255) ? len - 2 : 255;
        for (int i = 0; i < len; i++) begin
            body_byte = 8'($urandom());
            if (ftype == FT_PUBLISH && i == 1 && len >= 2 && $urandom_range(0, 7) != 0)
                body_byte = 8'($urandom_range(0, topic_max));
            if (ftype == FT_SUBACK && i == 2 && $urandom_range(0, 3) != 0)
                body_byte = $urandom_range(0, 1) ? 8'h80 : 8'h00;
            if (ftype == FT_CONNACK && i == 0 && $urandom_range(0, 1) == 0)
                body_byte = 8'h00;
            send_byte(body_byte);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
    endtask

    // en is indexed by register number
    task automatic write_enables(input logic [3:0] en);
        cfg_write(CFG_PUBLISH_EN, en[CFG_PUBLISH_EN]);
        cfg_write(CFG_PING_EN, en[CFG_PING_EN]);
        cfg_write(CFG_SUBSCRIBE_EN, en[CFG_SUBSCRIBE_EN]);
        cfg_write(CFG_UNSUB_EN, en[CFG_UNSUB_EN]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        en_publish = en[CFG_PUBLISH_EN];
        en_ping = en[CFG_PING_EN];
        en_sub = en[CFG_SUBSCRIBE_EN];
        en_unsub = en[CFG_UNSUB_EN];
    endtask

    // hold until every byte is taken and every result is in, then let the pipe settle
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // sender: bursts of random length separated by random gaps
    initial begin : sender
        int         burst_left, gap_left;
        logic       next_valid;
        logic [7:0] next_byte;
        burst_left = $urandom_range(1, 24);
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            next_valid = i_in_valid;
            next_byte = i_rx_byte;
            if (i_in_valid && !o_in_stall) begin
                bytes_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_queue.size() > 0) begin
                    next_byte = byte_queue.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_in_valid <= next_valid;
            i_rx_byte <= next_byte;
        end
    end

    // receiver: check each taken result, then pick the next stall
    initial begin : receiver
        t_result got, want;
        int      mode, mode_left, hold_left, tick;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_kind, o_data_byte, o_status, o_frame_type, o_packet_ident,
                       o_sub_granted, o_payload_length, o_frame_end};
                results_checked++;
                if (pending_results.size() == 0) begin
                    result_errors++;
                    if (result_errors <= 10)
                        $display("result %0d not expected: kind %0d status %0d type %0d",
                                 results_checked, got.kind, got.status, got.frame_type);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        result_errors++;
                        if (result_errors <= 10) begin
                            $display("result %0d mismatch (kind data status type ident %s",
                                     results_checked, "granted length end)");
                            $display("  expected %0d %h %0d %0d %h %0d %0d %0d",
                                     want.kind, want.data_byte, want.status, want.frame_type,
                                     want.packet_ident, want.sub_granted,
                                     want.payload_length, want.frame_end);
                            $display("  actual   %0d %h %0d %0d %h %0d %0d %0d",
                                     got.kind, got.data_byte, got.status, got.frame_type,
                                     got.packet_ident, got.sub_granted,
                                     got.payload_length, got.frame_end);
                        end
                    end
                end
            end
            if (hold_request) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            tick++;
            // long hold-off first, else the current stall pattern
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin : main
        logic [3:0] settings [6];
        t_result    typed_result;
        int         depth, base;
        bit         paused;
        settings = '{4'b1111, 4'b0000, 4'b0101, 4'b1010, 4'($urandom()), 4'b1111};
        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames with every handler on
        write_enables(4'b1111);
        foreach (directed_rows[i]) begin
            depth = pending_results.size();
            send_byte(directed_rows[i].rx);
            if (directed_rows[i].typed) begin
                while (pending_results.size() > depth)
                    void'(pending_results.pop_back());
                typed_result = '0;
                typed_result.kind = KIND_STATUS;
                typed_result.status = directed_rows[i].st;
                typed_result.frame_type = directed_rows[i].ft;
                typed_result.frame_end = 1'b1;
                pending_results.push_back(typed_result);
            end
        end
        wait_drained();

        // random frames under each handler setting
        foreach (settings[p]) begin
            write_enables(settings[p]);
            if (p == 2)
                hold_request = 1'b1;
            base = bytes_queued;
            while (bytes_queued - base < 205) begin
                send_frame();
                // pause the sender halfway through until every result is in
                if (p == 3 && !paused && bytes_queued - base >= 100) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        if (result_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
